// ----- hdl/dq_pkg.sv -----
`default_nettype none

package dq_pkg;

    // Ring buffer geometry.
    localparam int DEPTH      = 64;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W      = $clog2(DEPTH + 1);
    localparam int DATA_W     = 8;
    localparam int COUNT_W    = 7;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [OCC_W-1:0]  occ_t;
    typedef logic [DATA_W-1:0] byte_t;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_REAR  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_out;
    } dq_cmd_t;

    function automatic idx_t idx_inc(input idx_t i);
        return (i == IDX_LAST) ? '0 : idx_t'(i + 1'b1);
    endfunction

    function automatic idx_t idx_dec(input idx_t i);
        return (i == '0) ? IDX_LAST : idx_t'(i - 1'b1);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/dq_ctrl.sv -----
`default_nettype none

module dq_ctrl
    import dq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    output dq_cmd_t      cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd.accept   = (state_reg == S_IDLE) && in_valid;
        cmd.load_out = (state_reg == S_RESP) && (!out_valid_reg || !out_stall);

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (cmd.load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- hdl/dq_datapath.sv -----
`default_nettype none

module dq_datapath
    import dq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dq_cmd_t             cmd,
    input  wire logic [1:0]          req_type,
    input  wire logic [DATA_W-1:0]   push_byte,
    output logic [DATA_W-1:0]        pop_byte,
    output logic [1:0]               status,
    output logic                     is_empty,
    output logic [COUNT_W-1:0]       entry_count
);

    byte_t   slots [DEPTH];

    idx_t    head_reg;
    idx_t    head_next;
    idx_t    tail_reg;
    idx_t    tail_next;
    occ_t    occ_reg;
    occ_t    occ_next;

    // Per-request decode.
    req_t    req;
    logic    is_full;
    logic    is_void;
    logic    wr_en;
    idx_t    wr_addr;
    logic    rd_en;
    idx_t    rd_addr;
    status_t st_now;

    // Pending result between acceptance and output load.
    byte_t   rd_data_reg;
    logic    pop_ok_reg;
    status_t st_pend_reg;

    // Output registers.
    byte_t                pop_byte_reg;
    status_t              status_reg;
    logic                 is_empty_reg;
    logic [COUNT_W-1:0]   entry_count_reg;

    always_comb
    begin
        req       = req_t'(req_type);
        is_full   = (occ_reg == OCC_FULL);
        is_void   = (occ_reg == '0);
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        wr_en     = 1'b0;
        wr_addr   = tail_reg;
        rd_en     = 1'b0;
        rd_addr   = head_reg;
        st_now    = ST_OK;

        case (req)
            REQ_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    st_now = ST_FULL;
                end
                else
                begin
                    head_next = idx_dec(head_reg);
                    wr_en     = 1'b1;
                    wr_addr   = head_next;
                    occ_next  = occ_t'(occ_reg + 1'b1);
                end
            end
            REQ_PUSH_REAR:
            begin
                if (is_full)
                begin
                    st_now = ST_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_addr   = tail_reg;
                    tail_next = idx_inc(tail_reg);
                    occ_next  = occ_t'(occ_reg + 1'b1);
                end
            end
            REQ_POP_FRONT:
            begin
                if (is_void)
                begin
                    st_now = ST_EMPTY;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = head_reg;
                    head_next = idx_inc(head_reg);
                    occ_next  = occ_t'(occ_reg - 1'b1);
                end
            end
            REQ_POP_REAR:
            begin
                if (is_void)
                begin
                    st_now = ST_EMPTY;
                end
                else
                begin
                    tail_next = idx_dec(tail_reg);
                    rd_en     = 1'b1;
                    rd_addr   = tail_next;
                    occ_next  = occ_t'(occ_reg - 1'b1);
                end
            end
            default:
            begin
                st_now = ST_OK;
            end
        endcase
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
        begin
            slots[wr_addr] <= push_byte;
        end
        if (cmd.accept && rd_en)
        begin
            rd_data_reg <= slots[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pop_ok_reg  <= rd_en;
            st_pend_reg <= st_now;
        end
        if (cmd.load_out)
        begin
            pop_byte_reg    <= pop_ok_reg ? rd_data_reg : '0;
            status_reg      <= st_pend_reg;
            is_empty_reg    <= (occ_reg == '0);
            entry_count_reg <= COUNT_W'(occ_reg);
        end
    end

    assign pop_byte    = pop_byte_reg;
    assign status      = status_reg;
    assign is_empty    = is_empty_reg;
    assign entry_count = entry_count_reg;

endmodule

`default_nettype wire

// ----- hdl/double_ended_queue.sv -----
`default_nettype none

// Byte deque kept in a ring buffer of DEPTH entries (64 by default). Each
// input word is a request that pushes a byte at the front or rear or pops one
// from the front or rear, and each request gives exactly one output word with
// the popped byte (0 unless a pop succeeded), a status (ok, pop from empty,
// push into full), an empty flag and the entry count as they stand after the
// request. A push into a full deque is dropped and a pop from an empty one
// leaves the state unchanged. When a request is accepted, the pointers and
// count are updated and the slot memory is written or read; afterwards the
// registered memory read data is moved into the output register, and no new
// request is accepted before that move. The output register lets the next
// request be accepted while the previous result still waits on a stalled
// output. The slot memory needs no clearing after reset, since only slots
// that were pushed are ever read.
module double_ended_queue
    import dq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          req_type,
    input  wire logic [DATA_W-1:0]   push_byte,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [DATA_W-1:0]        pop_byte,
    output logic [1:0]               status,
    output logic                     is_empty,
    output logic [COUNT_W-1:0]       entry_count
);

    dq_cmd_t cmd;

    // Sequences acceptance of a request and loading of its result.
    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Holds the pointers, count, slot memory and output word.
    dq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_type),
        .push_byte   (push_byte),
        .pop_byte    (pop_byte),
        .status      (status),
        .is_empty    (is_empty),
        .entry_count (entry_count)
    );

endmodule

`default_nettype wire
